// File: design/double_ended_queue_unit_defines.svh
// Assertion macros for the double-ended queue unit.
// Used by double_ended_queue_unit.sv; each macro expects clk and rst in scope.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dq_pkg.sv
// Shared sizes, codes and ring arithmetic for the double-ended queue unit.
// No dependencies; imported by double_ended_queue_unit.
package dq_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_LIST       = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } dq_state_t;

  // Slot at a given distance from base, both below DEPTH, wrapped around the ring.
  function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] offs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      sum = sum - (IDX_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// File: design/double_ended_queue_unit.sv
// Double-ended queue unit: ring store, head pointer, entry count and control FSM.
// Depends on dq_pkg and double_ended_queue_unit_defines.svh.
//
// Usage:
// The input channel (in_valid, in_stall, kind, value) carries one command per
// beat: push front, push back, pop front, pop back, or list all entries from
// front to back. The output channel (out_valid, out_stall, value_res, status,
// count, last) returns the results. Pushes and pops give one result beat; a
// list gives one beat per held entry, or a single empty beat, with last set on
// the final beat. Unknown kinds are dropped with no result.
// Flow: a command is taken in ST_IDLE and its memory read comes back in the
// next cycle, in ST_EXEC, where the result is loaded into the output register
// once that register is free. A push or pop passes through ST_IDLE and ST_EXEC
// once; a list stays in ST_EXEC, where the single read port of the ring store
// streams one entry per cycle unless the output stalls. The output register lets
// the next command be taken while the previous result still waits to be taken.
// Reset empties the queue (head and count to zero); the ring contents are not
// cleared. When the receiver stalls, the pending result holds and the unit
// waits with in_stall high until the output register frees up.
`include "double_ended_queue_unit_defines.svh"

module double_ended_queue_unit
  import dq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic signed [DATA_W-1:0] value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [DATA_W-1:0] value_res,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  count,
  output logic                last
);

  // Ring store: one write port, one registered read port.
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic              mem_re;
  logic              mem_we;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;

  dq_state_t         state, state_next;
  logic [IDX_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [IDX_W-1:0]  pos, pos_next;
  logic [KIND_W-1:0] kind_q;
  logic [DATA_W-1:0] value_q;

  logic              out_load;
  logic [DATA_W-1:0] res_value;
  status_t           res_status;
  logic              res_last;

  logic              out_free;
  logic              is_full;
  logic              is_empty;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  head_dec;
  logic [IDX_W-1:0]  pos_inc;

  assign out_free = !out_valid || !out_stall;
  assign is_full  = (entry_count == CNT_W'(DEPTH));
  assign is_empty = (entry_count == '0);
  assign cnt_m1   = entry_count - 1'b1;
  assign head_dec = (head == '0) ? IDX_W'(DEPTH - 1) : head - 1'b1;
  assign pos_inc  = pos + 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= value_q;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    state_next       = state;
    in_stall         = (state != ST_IDLE);
    mem_re           = 1'b0;
    mem_we           = 1'b0;
    rd_addr          = head;
    wr_addr          = head;
    head_next        = head;
    entry_count_next = entry_count;
    pos_next         = pos;
    out_load         = 1'b0;
    res_value        = '0;
    res_status       = STATUS_OK;
    res_last         = 1'b1;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          // Start the read for pops and lists right away; pushes ignore it.
          state_next = ST_EXEC;
          mem_re     = 1'b1;
          pos_next   = '0;
          if (kind == KIND_POP_BACK) begin
            rd_addr = ring_slot(head, cnt_m1[IDX_W-1:0]);
          end
        end
      end
      ST_EXEC: begin
        case (kind_q)
          KIND_PUSH_FRONT: begin
            if (out_free) begin
              out_load   = 1'b1;
              state_next = ST_IDLE;
              if (is_full) begin
                res_status = STATUS_FULL;
              end else begin
                mem_we           = 1'b1;
                wr_addr          = head_dec;
                head_next        = head_dec;
                entry_count_next = entry_count + 1'b1;
              end
            end
          end
          KIND_PUSH_BACK: begin
            if (out_free) begin
              out_load   = 1'b1;
              state_next = ST_IDLE;
              if (is_full) begin
                res_status = STATUS_FULL;
              end else begin
                mem_we           = 1'b1;
                wr_addr          = ring_slot(head, entry_count[IDX_W-1:0]);
                entry_count_next = entry_count + 1'b1;
              end
            end
          end
          KIND_POP_FRONT: begin
            if (out_free) begin
              out_load   = 1'b1;
              state_next = ST_IDLE;
              if (is_empty) begin
                res_status = STATUS_EMPTY;
              end else begin
                res_value        = rd_data;
                head_next        = ring_slot(head, IDX_W'(1));
                entry_count_next = cnt_m1;
              end
            end
          end
          KIND_POP_BACK: begin
            if (out_free) begin
              out_load   = 1'b1;
              state_next = ST_IDLE;
              if (is_empty) begin
                res_status = STATUS_EMPTY;
              end else begin
                res_value        = rd_data;
                entry_count_next = cnt_m1;
              end
            end
          end
          KIND_LIST: begin
            if (out_free) begin
              out_load = 1'b1;
              if (is_empty) begin
                res_status = STATUS_EMPTY;
                state_next = ST_IDLE;
              end else begin
                // Emit the entry in hand and fetch the next one in the same cycle.
                res_value = rd_data;
                res_last  = (pos == cnt_m1[IDX_W-1:0]);
                if (res_last) begin
                  state_next = ST_IDLE;
                end else begin
                  pos_next = pos_inc;
                  mem_re   = 1'b1;
                  rd_addr  = ring_slot(head, pos_inc);
                end
              end
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      head        <= '0;
      entry_count <= '0;
      pos         <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      head        <= head_next;
      entry_count <= entry_count_next;
      pos         <= pos_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      kind_q  <= kind;
      value_q <= value;
    end
    if (out_load) begin
      value_res <= res_value;
      status    <= res_status;
      count     <= COUNT_W'(entry_count_next);
      last      <= res_last;
    end
  end

  `DQ_ASSERT_NOW(a_count_bound, 1'b1, entry_count <= CNT_W'(DEPTH), "entry count above depth")
  `DQ_ASSERT_NEXT(a_list_continues, out_load && !res_last, state == ST_EXEC, "list run ended early")
  `DQ_ASSERT_NEXT(a_push_grows, out_load && kind_q == KIND_PUSH_BACK && res_status == STATUS_OK, entry_count == CNT_W'($past(entry_count) + 1'b1), "push did not grow count")
  `DQ_ASSERT_NOW(a_unknown_silent, state == ST_EXEC && kind_q > KIND_LIST, !out_load && !mem_we, "unknown kind produced activity")

endmodule
